// File: sv/dva_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the drum voice allocator.
// No dependencies; every other file imports this package.
package dva_pkg;

  localparam int DVA_VOICES      = 4;
  localparam int DVA_QUEUE_DEPTH = 4;

  // event kinds carried in in_tuser
  typedef enum logic [1:0] {
    MODE_NOTE_ON  = 2'd0,
    MODE_FINISHED = 2'd1,
    MODE_NOTE_OFF = 2'd2
  } dva_mode_t;

  localparam logic [7:0] NO_NOTE = 8'hFF;

  localparam int PNUM_W  = 26;
  localparam int AMP_W   = 16;
  localparam int NOTE_W  = 7;
  localparam int POLE_W  = 17;

  // pole = floor((65470964 - 600*a) / 1000), division by reciprocal multiply
  localparam logic [PNUM_W-1:0] POLE_BIAS  = 26'd65470964;
  localparam logic [9:0]        POLE_STEP  = 10'd600;
  localparam logic [26:0]       POLE_RECIP = 27'd68719477;
  localparam int                POLE_SHIFT = 36;

  // note-off gain = floor((a + 50) / 100)
  localparam logic [16:0] GAIN_BIAS  = 17'd50;
  localparam logic [17:0] GAIN_RECIP = 18'd167773;
  localparam int          GAIN_SHIFT = 24;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } dva_qstat_t;

  // width of one queued job: on flag, voice, note, reused, stolen,
  // pole numerator, amplitude, active count
  function automatic int dva_job_w(input int voices);
    return 1 + $clog2(voices) + NOTE_W + 1 + 1 + PNUM_W + AMP_W + $clog2(voices + 1);
  endfunction

endpackage

// File: sv/drum_voice_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the drum voice allocator: front end, job queue, back end.
// Depends on dva_pkg, dva_front, dva_queue and dva_back.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid/in_tready   | tuser: mode; tdata: note, amplitude, voice
//  out_    | output    | out_tvalid/out_tready | tdata: voice fields, pole, gain; tlast: last
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_data: ignore_note_off
//
// The front takes one event a cycle while the job queue has room; the
// allocation update is done in that same cycle.
// The back end hands out one result a cycle while out_tready lets the output
// register drain: one for a note-on, one per active voice for a note-off; the
// pole and gain multipliers sit between the job register and the output register.
// Reset clears all voices to idle at once, no sweep. cfg_ready is always high.
// A stalled output fills the queue, then in_tready drops.
module drum_voice_allocator_core #(
  parameter int VOICES      = dva_pkg::DVA_VOICES,
  parameter int QUEUE_DEPTH = dva_pkg::DVA_QUEUE_DEPTH,
  localparam int VW         = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int IN_TW      = ((23 + VW + 7) / 8) * 8,
  localparam int OUT_TW     = ((43 + VW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // note[6:0], amplitude[22:7], voice above, zero pad
  input  logic [1:0]        in_tuser,   // mode[1:0]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // voice_index, start_res, out_note, reused,
                                        // stolen, pole, gain, zero pad
  output logic              out_tlast
);
  import dva_pkg::*;

  localparam int JOB_W = dva_job_w(VOICES);

  logic             q_push, q_pop;
  logic [JOB_W-1:0] q_wdata, q_rdata;
  dva_qstat_t       q_stat;

  assign cfg_ready = 1'b1;

  dva_front #(.VOICES(VOICES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_stat    (q_stat)
  );

  dva_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head_data (q_rdata),
    .stat      (q_stat)
  );

  dva_back #(.VOICES(VOICES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_rdata),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sv/dva_queue.sv
`timescale 1ns / 1ps
// Short job queue between the allocation front and the result back end.
// Depends on dva_pkg for the status struct.
module dva_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   head_data,
  output dva_pkg::dva_qstat_t stat
);
  import dva_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// File: sv/dva_front.sv
`timescale 1ns / 1ps
// Front end: takes events, keeps voice ages, notes and active count, picks
// the voice for a note-on and queues one job per event that gives results.
// Depends on dva_pkg.
module dva_front #(
  parameter int VOICES = dva_pkg::DVA_VOICES,
  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int IN_TW = ((23 + VW + 7) / 8) * 8,
  localparam int JOB_W = dva_pkg::dva_job_w(VOICES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_TW-1:0]   in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  output logic               q_push,
  output logic [JOB_W-1:0]   q_data,
  input  dva_pkg::dva_qstat_t q_stat
);
  import dva_pkg::*;

  localparam int AGE_W = VW + 1;
  localparam int CNT_W = $clog2(VOICES + 1);

  logic signed [AGE_W-1:0] age_r [VOICES];
  logic signed [AGE_W-1:0] age_nxt [VOICES];
  logic [7:0]              note_r [VOICES];
  logic [7:0]              note_nxt [VOICES];
  logic [VOICES-1:0]       fin_r, fin_nxt;
  logic [CNT_W-1:0]        act_r, act_nxt;
  logic                    ign_r;

  logic [NOTE_W-1:0] in_note;
  logic [AMP_W-1:0]  in_amp;
  logic [VW-1:0]     in_voice;
  dva_mode_t         in_mode;
  logic              in_acc;

  logic              reuse_hit;
  logic [VW-1:0]     reuse_idx, idle_idx, old_idx;
  logic              idle_hit, old_hit;
  logic              fv_hit;
  logic signed [AGE_W-1:0] fv_age, old_age;

  logic              j_on, j_reused, j_stolen;
  logic [VW-1:0]     j_sel;
  logic [NOTE_W-1:0] j_note;
  logic [PNUM_W-1:0] j_pnum;

  assign in_note  = in_tdata[6:0];
  assign in_amp   = in_tdata[22:7];
  assign in_voice = in_tdata[22+VW:23];
  assign in_mode  = dva_mode_t'(in_tuser);
  assign in_tready = !q_stat.full;
  assign in_acc   = in_tvalid && in_tready;

  // pole numerator; the division by 1000 is left to the back end
  assign j_pnum = POLE_BIAS - PNUM_W'(in_amp * POLE_STEP);

  // voice searches, lowest index wins
  always_comb begin
    reuse_hit = 1'b0;
    reuse_idx = '0;
    idle_hit  = 1'b0;
    idle_idx  = '0;
    old_hit   = 1'b0;
    old_idx   = '0;
    fv_hit    = 1'b0;
    fv_age    = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!reuse_hit && note_r[i] == {1'b0, in_note} && fin_r[i] && age_r[i][AGE_W-1]
          && act_r < CNT_W'(VOICES)) begin
        reuse_hit = 1'b1;
        reuse_idx = VW'(i);
      end
      if (!idle_hit && age_r[i][AGE_W-1]) begin
        idle_hit = 1'b1;
        idle_idx = VW'(i);
      end
      if (!old_hit && age_r[i] == '0) begin
        old_hit = 1'b1;
        old_idx = VW'(i);
      end
      if (in_voice == VW'(i)) begin
        fv_hit = 1'b1;
        fv_age = age_r[i];
      end
    end
  end

  assign old_age = age_r[old_idx];

  always_comb begin
    age_nxt  = age_r;
    note_nxt = note_r;
    fin_nxt  = fin_r;
    act_nxt  = act_r;
    q_push   = 1'b0;
    j_on     = 1'b0;
    j_reused = 1'b0;
    j_stolen = 1'b0;
    j_sel    = '0;
    j_note   = '0;
    if (in_acc) begin
      unique case (in_mode)
        MODE_NOTE_ON: begin
          q_push = 1'b1;
          j_on   = 1'b1;
          j_note = in_note;
          if (reuse_hit) begin
            j_sel    = reuse_idx;
            j_reused = 1'b1;
            age_nxt[reuse_idx] = AGE_W'(act_r);
            act_nxt  = act_r + CNT_W'(1);
          end else if (act_r < CNT_W'(VOICES)) begin
            j_sel    = idle_idx;
            age_nxt[idle_idx]  = AGE_W'(act_r);
            note_nxt[idle_idx] = {1'b0, in_note};
            act_nxt  = act_r + CNT_W'(1);
          end else begin
            // take the oldest voice, move the younger ones one age down
            j_sel    = old_idx;
            j_stolen = 1'b1;
            for (int j = 0; j < VOICES; j++) begin
              if (age_r[j] > old_age) begin
                age_nxt[j] = age_r[j] - AGE_W'(1);
              end
            end
            age_nxt[old_idx]  = AGE_W'(act_r - CNT_W'(1));
            note_nxt[old_idx] = {1'b0, in_note};
          end
          fin_nxt[j_sel] = 1'b0;
        end
        MODE_FINISHED: begin
          if (fv_hit) begin
            if (!fv_age[AGE_W-1]) begin
              for (int j = 0; j < VOICES; j++) begin
                if (age_r[j] > fv_age) begin
                  age_nxt[j] = age_r[j] - AGE_W'(1);
                end
              end
              age_nxt[in_voice] = '1;
              if (act_r != '0) begin
                act_nxt = act_r - CNT_W'(1);
              end
            end
            fin_nxt[in_voice] = 1'b1;
          end
        end
        MODE_NOTE_OFF: begin
          q_push = !ign_r && (act_r != '0);
        end
        default: begin
          // unused kind: drop
        end
      endcase
    end
  end

  assign q_data = {act_r, in_amp, j_pnum, j_stolen, j_reused, j_note, j_sel, j_on};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        age_r[i]  <= '1;
        note_r[i] <= NO_NOTE;
      end
      fin_r <= '1;
      act_r <= '0;
      ign_r <= 1'b0;
    end else begin
      age_r  <= age_nxt;
      note_r <= note_nxt;
      fin_r  <= fin_nxt;
      act_r  <= act_nxt;
      if (cfg_valid) begin
        ign_r <= cfg_data;
      end
    end
  end

`ifndef SYNTH
  a_act_bound: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= CNT_W'(VOICES))
    else $error("active count above voice count");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_on_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode == MODE_NOTE_ON |=> act_r != '0)
    else $error("note-on left no active voice");
`endif

endmodule

// File: sv/dva_back.sv
`timescale 1ns / 1ps
// Back end: pops jobs, works out pole and gain and hands out one result per
// cycle into the output register while it is free or being taken. Depends on dva_pkg.
module dva_back #(
  parameter int VOICES  = dva_pkg::DVA_VOICES,
  localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int OUT_TW = ((43 + VW + 7) / 8) * 8,
  localparam int JOB_W  = dva_pkg::dva_job_w(VOICES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [JOB_W-1:0]   q_data,
  input  dva_pkg::dva_qstat_t q_stat,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_TW-1:0]  out_tdata,
  output logic               out_tlast
);
  import dva_pkg::*;

  localparam int CNT_W = $clog2(VOICES + 1);

  // head of queue
  logic              h_on, h_reused, h_stolen;
  logic [VW-1:0]     h_sel;
  logic [NOTE_W-1:0] h_note;
  logic [PNUM_W-1:0] h_pnum;
  logic [AMP_W-1:0]  h_amp;
  logic [CNT_W-1:0]  h_cnt;

  // job in progress
  logic              cur_valid_r, cur_valid_nxt;
  logic              cur_on_r, cur_reused_r, cur_stolen_r;
  logic [VW-1:0]     cur_sel_r;
  logic [NOTE_W-1:0] cur_note_r;
  logic [PNUM_W-1:0] cur_pnum_r;
  logic [AMP_W-1:0]  cur_amp_r;
  logic [CNT_W-1:0]  cur_cnt_r;
  logic [VW-1:0]     idx_r, idx_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [VW-1:0]     out_vi_r;
  logic              out_start_r, out_reused_r, out_stolen_r, out_last_r;
  logic [NOTE_W-1:0] out_note_r;
  logic [POLE_W-1:0] out_pole_r;
  logic [AMP_W-1:0]  out_gain_r;

  logic              adv, cur_last;
  logic [52:0]       pole_prod;
  logic [16:0]       gain_num;
  logic [34:0]       gain_prod;

  assign {h_cnt, h_amp, h_pnum, h_stolen, h_reused, h_note, h_sel, h_on} = q_data;

  assign adv      = cur_valid_r && (!out_valid_r || out_tready);
  assign cur_last = cur_on_r || (CNT_W'(idx_r) + CNT_W'(1) == cur_cnt_r);
  assign q_pop    = !q_stat.empty && (!cur_valid_r || (adv && cur_last));

  assign pole_prod = 53'(cur_pnum_r) * 53'(POLE_RECIP);
  assign gain_num  = 17'(cur_amp_r) + GAIN_BIAS;
  assign gain_prod = 35'(gain_num) * 35'(GAIN_RECIP);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      if (cur_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + VW'(1);
      end
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_on_r     <= h_on;
      cur_reused_r <= h_reused;
      cur_stolen_r <= h_stolen;
      cur_sel_r    <= h_sel;
      cur_note_r   <= h_note;
      cur_pnum_r   <= h_pnum;
      cur_amp_r    <= h_amp;
      cur_cnt_r    <= h_cnt;
    end
    if (adv) begin
      out_last_r <= cur_last;
      if (cur_on_r) begin
        out_vi_r     <= cur_sel_r;
        out_start_r  <= 1'b1;
        out_note_r   <= cur_note_r;
        out_reused_r <= cur_reused_r;
        out_stolen_r <= cur_stolen_r;
        out_pole_r   <= pole_prod[POLE_SHIFT +: POLE_W];
        out_gain_r   <= cur_amp_r;
      end else begin
        out_vi_r     <= idx_r;
        out_start_r  <= 1'b0;
        out_note_r   <= '0;
        out_reused_r <= 1'b0;
        out_stolen_r <= 1'b0;
        out_pole_r   <= '0;
        out_gain_r   <= 16'(gain_prod[34:GAIN_SHIFT]);
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    out_tdata[VW-1:0]              = out_vi_r;
    out_tdata[VW]                  = out_start_r;
    out_tdata[VW+7:VW+1]           = out_note_r;
    out_tdata[VW+8]                = out_reused_r;
    out_tdata[VW+9]                = out_stolen_r;
    out_tdata[VW+26:VW+10]         = out_pole_r;
    out_tdata[VW+42:VW+27]         = out_gain_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_start_r |-> out_last_r)
    else $error("note-on result without last");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && !cur_on_r |-> CNT_W'(idx_r) < cur_cnt_r)
    else $error("note-off index past active count");

  a_job_drains: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cur_last && !q_pop |=> !cur_valid_r)
    else $error("finished job still held");
`endif

endmodule

// File: sim/drum_voice_allocator_checker.sv
`timescale 1ns / 1ps
// Scoreboard for drum_voice_allocator_core: watches the request, result and
// register channels, predicts each result from its own voice state, compares.
// Depends on dva_pkg.
module drum_voice_allocator_checker #(
  parameter int IN_TW  = 32,
  parameter int OUT_TW = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // note, amplitude, voice, zero pad
  input  logic [1:0]        in_tuser,   // mode
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_TW-1:0] out_tdata,  // voice_index, start_res, out_note, reused,
                                        // stolen, pole, gain, zero pad
  input  logic              out_tlast,
  output int                errors,
  output int                pending
);
  import dva_pkg::*;

  localparam int VW = $clog2(DVA_VOICES);
  // 0.999 * 65536 scaled by 1000, plus half a step so the divide rounds
  localparam int unsigned POLE_NUM    = 32'd65470464 + 32'd500;
  localparam int unsigned POLE_SLOPE  = 32'd600;
  localparam int unsigned POLE_DIV    = 32'd1000;
  localparam int unsigned RELEASE_RND = 32'd50;
  localparam int unsigned RELEASE_DIV = 32'd100;

  // same order as out_tdata from the lowest bit up, with tlast on top
  typedef struct packed {
    logic              last;
    logic [AMP_W-1:0]  gain;
    logic [POLE_W-1:0] pole;
    logic              stolen;
    logic              reused;
    logic [NOTE_W-1:0] note;
    logic              start_res;
    logic [VW-1:0]     voice_idx;
  } voice_result_t;

  voice_result_t expected_results[$];
  voice_result_t want;
  voice_result_t got;

  int         voice_age  [DVA_VOICES];  // -1 idle, 0 oldest
  logic [7:0] voice_note [DVA_VOICES];
  logic       voice_done [DVA_VOICES];
  int         active_voices;
  logic       note_off_muted;
  int         err_cnt = 0;

  function automatic void compare_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
    if (exp_val != act_val) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endfunction

  function automatic void allocate_voices(input logic [1:0] mode,
                                          input logic [NOTE_W-1:0] note,
                                          input logic [AMP_W-1:0] amp,
                                          input logic [VW-1:0] v);
    int            sel;
    int            oldest;
    int unsigned   calc;
    voice_result_t r;
    sel = -1;
    r   = '0;
    case (mode)
      MODE_NOTE_ON: begin
        // reuse a finished voice still holding this note
        for (int i = 0; i < DVA_VOICES; i++)
          if (sel < 0 && voice_note[i] == {1'b0, note} && voice_done[i] &&
              voice_age[i] < 0 && active_voices < DVA_VOICES)
            sel = i;
        if (sel >= 0) begin
          r.reused       = 1'b1;
          voice_age[sel] = active_voices;
          active_voices++;
        end else begin
          if (active_voices < DVA_VOICES) begin
            for (int i = 0; i < DVA_VOICES; i++)
              if (sel < 0 && voice_age[i] < 0) sel = i;
            if (sel < 0) sel = 0;
            active_voices++;
          end else begin
            // steal the oldest, move every younger voice one age down
            r.stolen = 1'b1;
            for (int i = 0; i < DVA_VOICES; i++)
              if (sel < 0 && voice_age[i] == 0) sel = i;
            if (sel < 0) sel = 0;
            oldest = voice_age[sel];
            for (int j = 0; j < DVA_VOICES; j++)
              if (voice_age[j] > oldest) voice_age[j]--;
          end
          voice_age[sel]  = active_voices - 1;
          voice_note[sel] = {1'b0, note};
        end
        voice_done[sel] = 1'b0;
        calc = (POLE_NUM - POLE_SLOPE * 32'(amp)) / POLE_DIV;
        r.voice_idx = sel[VW-1:0];
        r.start_res = 1'b1;
        r.note      = note;
        r.pole      = calc[POLE_W-1:0];
        r.gain      = amp;
        r.last      = 1'b1;
        expected_results.push_back(r);
      end
      MODE_FINISHED: begin
        // free the voice and close the gap it leaves in the ages
        if (voice_age[v] >= 0) begin
          oldest = voice_age[v];
          for (int j = 0; j < DVA_VOICES; j++)
            if (voice_age[j] > oldest) voice_age[j]--;
          voice_age[v] = -1;
          if (active_voices > 0) active_voices--;
        end
        voice_done[v] = 1'b1;
      end
      MODE_NOTE_OFF: begin
        if (!note_off_muted) begin
          calc = (32'(amp) + RELEASE_RND) / RELEASE_DIV;
          for (int i = 0; i < active_voices && i < DVA_VOICES; i++) begin
            r           = '0;
            r.voice_idx = i[VW-1:0];
            r.gain      = calc[AMP_W-1:0];
            r.last      = (i + 1 == active_voices);
            expected_results.push_back(r);
          end
        end
      end
      default: ;  // unused mode: drop
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DVA_VOICES; i++) begin
        voice_age[i]  = -1;
        voice_note[i] = NO_NOTE;
        voice_done[i] = 1'b1;
      end
      active_voices  = 0;
      note_off_muted = 1'b0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata[$bits(voice_result_t)-2:0]};
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t: stray result, expected none, actual voice %0d gain %0d last %0b",
                   $time, got.voice_idx, got.gain, got.last);
        end else begin
          want = expected_results.pop_front();
          compare_field("voice_index", want.voice_idx, got.voice_idx);
          compare_field("start_res", want.start_res, got.start_res);
          compare_field("out_note", want.note, got.note);
          compare_field("reused", want.reused, got.reused);
          compare_field("stolen", want.stolen, got.stolen);
          compare_field("pole", want.pole, got.pole);
          compare_field("gain", want.gain, got.gain);
          compare_field("last", want.last, got.last);
        end
      end
      // a request taken on the same edge still sees the old register value
      if (in_tvalid && in_tready)
        allocate_voices(in_tuser, in_tdata[NOTE_W-1:0], in_tdata[NOTE_W+AMP_W-1:NOTE_W],
                        in_tdata[NOTE_W+AMP_W+VW-1:NOTE_W+AMP_W]);
      if (cfg_valid && cfg_ready) note_off_muted = cfg_data;
    end
    errors  <= err_cnt;
    pending <= expected_results.size();
  end

endmodule

// File: sim/drum_voice_allocator_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for drum_voice_allocator_core: clock, reset, request stimulus,
// receiver back-pressure, stall watchdog and the verdict.
// Depends on dva_pkg, drum_voice_allocator_core and drum_voice_allocator_checker.
module drum_voice_allocator_core_tb;
  import dva_pkg::*;

  localparam int VW           = $clog2(DVA_VOICES);
  localparam int IN_TW        = ((23 + VW + 7) / 8) * 8;
  localparam int OUT_TW       = ((43 + VW + 7) / 8) * 8;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE       = 40;    // queued jobs without results, then the output stage
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_EVENTS = 32;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata   = '0;   // note, amplitude, voice, zero pad
  logic [1:0]        in_tuser   = '0;   // mode
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic              cfg_data   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;         // voice_index, start_res, out_note, reused,
                                        // stolen, pole, gain, zero pad
  logic              out_tlast;
  int                fail_count;
  int                pending;
  int                send_idle    = 28;
  int                recv_idle    = 75;
  int                quiet_cycles = 0;

  drum_voice_allocator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  drum_voice_allocator_checker #(
    .IN_TW  (IN_TW),
    .OUT_TW (OUT_TW)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic [1:0] mode, input logic [NOTE_W-1:0] note,
                            input logic [AMP_W-1:0] amp, input logic [VW-1:0] voice);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_TW-NOTE_W-AMP_W-VW){1'b0}}, voice, amp, note};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold requests until every predicted result has been taken
  task automatic wait_drained(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_skip(input logic value);
    wait_drained(SETTLE);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_events(input int count);
    int unsigned     pick;
    logic [1:0]      mode;
    logic [NOTE_W-1:0] note;
    logic [AMP_W-1:0]  amp;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_drained(0);
      pick = $urandom_range(99);
      if (pick < 45)      mode = MODE_NOTE_ON;
      else if (pick < 70) mode = MODE_FINISHED;
      else if (pick < 93) mode = MODE_NOTE_OFF;
      else                mode = MODE_UNUSED;
      // mostly a small kit so that finished voices come back for the same note
      if ($urandom_range(3) == 0) note = NOTE_W'($urandom_range(127));
      else note = NOTE_W'(36 + 2 * $urandom_range(3));
      case ($urandom_range(7))
        0:       amp = '0;
        1:       amp = '1;
        default: amp = AMP_W'($urandom_range(65535));
      endcase
      send_event(mode, note, amp, VW'($urandom_range(DVA_VOICES - 1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_skip(1'b0);

    // note-off with nothing sounding, then fill every voice and steal the oldest
    send_event(MODE_NOTE_OFF, 7'd0,   16'hFFFF, 2'd0);
    send_event(MODE_NOTE_ON,  7'd0,   16'd0,    2'd0);
    send_event(MODE_NOTE_ON,  7'd127, 16'hFFFF, 2'd3);
    send_event(MODE_NOTE_ON,  7'd5,   16'd1,    2'd0);
    send_event(MODE_NOTE_ON,  7'd9,   16'd32768, 2'd1);
    send_event(MODE_NOTE_ON,  7'd42,  16'd50,   2'd2);
    // release gains around the rounding points
    send_event(MODE_NOTE_OFF, 7'd0,   16'hFFFF, 2'd0);
    send_event(MODE_NOTE_OFF, 7'd0,   16'd49,   2'd0);
    send_event(MODE_NOTE_OFF, 7'd0,   16'd50,   2'd0);
    send_event(MODE_NOTE_OFF, 7'd0,   16'd150,  2'd0);
    // free a voice twice, then take it back with its own note
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd2);
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd2);
    send_event(MODE_NOTE_ON,  7'd5,   16'hFFFF, 2'd0);
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd3);
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd0);
    send_event(MODE_NOTE_ON,  7'd100, 16'd12345, 2'd0);
    send_event(MODE_UNUSED,   7'd127, 16'hFFFF, 2'd3);
    send_event(MODE_NOTE_OFF, 7'd0,   16'd0,    2'd0);
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd0);
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd1);
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd2);
    send_event(MODE_FINISHED, 7'd0,   16'd0,    2'd3);
    send_event(MODE_NOTE_OFF, 7'd0,   16'd1000, 2'd0);
    write_skip(1'b1);
    send_event(MODE_NOTE_ON,  7'd127, 16'd0,    2'd0);
    send_event(MODE_NOTE_OFF, 7'd0,   16'hFFFF, 2'd0);

    write_skip(1'b0);
    random_events(PHASE_EVENTS);

    send_idle = 75;
    recv_idle <= 28;
    write_skip(1'b1);
    random_events(PHASE_EVENTS);

    send_idle = 0;
    recv_idle <= 0;
    write_skip(1'b0);
    random_events(PHASE_EVENTS);

    wait_drained(SETTLE);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/dva_pkg.sv
sv/dva_queue.sv
sv/dva_front.sv
sv/dva_back.sv
sv/drum_voice_allocator_core.sv
sim/drum_voice_allocator_checker.sv
sim/drum_voice_allocator_core_tb.sv
